### hdl/mcvp_pkg.sv
// Shared types and constants for the minimum-cost vertical path block.
// Used by the register file, the controller, the interfaces and the top level.
// No dependencies.
package mcvp_pkg;

  // Widths of the configuration registers and of the channel fields.
  localparam int unsigned COLS_W    = 9;
  localparam int unsigned ROWS_W    = 11;
  localparam int unsigned PEN_W     = 16;
  localparam int unsigned COST_W    = 16;
  localparam int unsigned PROW_W    = 10;
  localparam int unsigned PCOL_W    = 8;
  localparam int unsigned APB_ADDR_W = 4;
  localparam int unsigned APB_DATA_W = 32;

  // Register indexes, taken from paddr[3:2].
  localparam logic [1:0] REG_COLS    = 2'd0;
  localparam logic [1:0] REG_ROWS    = 2'd1;
  localparam logic [1:0] REG_PENALTY = 2'd2;

  localparam logic [COLS_W-1:0] COLS_RESET    = 9'd256;
  localparam logic [ROWS_W-1:0] ROWS_RESET    = 11'd1024;
  localparam logic [PEN_W-1:0]  PENALTY_RESET = 16'd0;

  // Input item codes.
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_READ = 1'b1;

  // Back pointer codes; the spare code reads as a straight move.
  localparam logic [1:0] MV_UP    = 2'd0;
  localparam logic [1:0] MV_LEFT  = 2'd1;
  localparam logic [1:0] MV_RIGHT = 2'd2;

  typedef struct packed {
    logic [COLS_W-1:0] cols_in_use;
    logic [ROWS_W-1:0] rows_in_use;
    logic [PEN_W-1:0]  step_penalty;
  } cfg_t;

  typedef struct packed {
    logic              status;
    logic [PROW_W-1:0] path_row;
    logic [PCOL_W-1:0] path_col;
    logic              last;
  } res_t;

endpackage

### hdl/mcvp_if.sv
// Valid/ready channel interfaces for the input items and the result items.
// Depends on mcvp_pkg for the field widths.
interface mcvp_in_if;
  logic                          valid;
  logic                          ready;
  logic                          mode;
  logic [mcvp_pkg::COST_W-1:0]   cost;

  modport source (output valid, output mode, output cost, input ready);
  modport sink   (input valid, input mode, input cost, output ready);
endinterface

interface mcvp_out_if;
  logic                          valid;
  logic                          ready;
  logic                          status;
  logic [mcvp_pkg::PROW_W-1:0]   path_row;
  logic [mcvp_pkg::PCOL_W-1:0]   path_col;
  logic                          last;

  modport source (output valid, output status, output path_row, output path_col,
                  output last, input ready);
  modport sink   (input valid, input status, input path_row, input path_col,
                  input last, output ready);
endinterface

### hdl/min_cost_vertical_path_dp_top.sv
// Least-cost vertical path through a cost map.
// Input channel in_i: each transfer carries mode and cost. A load item (mode 0)
// adds the next raster-order cost sample to the running row sums and, past row 0,
// stores one back pointer; a read item (mode 1) yields one path point on out_o,
// starting at the last row and working up to row 0, where last is set. Reads before
// the map is complete, or after row 0, return status 1 with all other fields zero.
// A load item keeps the block busy through acceptance, two reads of the
// row-sum memory, the three-way compare and the write-back, set by the single
// read port of that memory. A read item passes through one back-pointer memory
// read (skipped when no trace step is due), then the output register.
// APB-style port sets map size and diagonal penalty; write it only while idle.
// Reset returns the registers to 256 columns, 1024 rows and zero penalty, and
// marks the map as not loaded. The memories need no clearing pass.
// When the receiver stalls, the result waits in the output register; loads
// carry on, and a further read waits, holding off the input, until that register is taken.
// Depends on mcvp_pkg, mcvp_if, mcvp_regs and mcvp_ctrl.
module min_cost_vertical_path_dp_top #(
  parameter int unsigned MAX_COLS = 256,
  parameter int unsigned MAX_ROWS = 1024,
  parameter int unsigned SUM_BITS = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [mcvp_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [mcvp_pkg::APB_DATA_W-1:0] pwdata,
  output logic [mcvp_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready,
  mcvp_in_if.sink                         in_i,
  mcvp_out_if.source                      out_o
);

  mcvp_pkg::cfg_t cfg;

  mcvp_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  mcvp_ctrl #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS),
    .SUM_BITS (SUM_BITS)
  ) u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .in_i   (in_i),
    .out_o  (out_o)
  );

endmodule

### hdl/mcvp_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module mcvp_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/mcvp_regs.sv
// APB-style configuration registers: map size and diagonal step penalty.
// Depends on mcvp_pkg for the register indexes, reset values and cfg_t.
module mcvp_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [mcvp_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [mcvp_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [mcvp_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready,
  output mcvp_pkg::cfg_t                      cfg_o
);

  mcvp_pkg::cfg_t cfg_q;
  logic [1:0]     index;
  logic           wr_en;

  assign index  = paddr[3:2];
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cols_in_use  <= mcvp_pkg::COLS_RESET;
      cfg_q.rows_in_use  <= mcvp_pkg::ROWS_RESET;
      cfg_q.step_penalty <= mcvp_pkg::PENALTY_RESET;
    end else if (wr_en) begin
      unique case (index)
        mcvp_pkg::REG_COLS:    cfg_q.cols_in_use  <= pwdata[mcvp_pkg::COLS_W-1:0];
        mcvp_pkg::REG_ROWS:    cfg_q.rows_in_use  <= pwdata[mcvp_pkg::ROWS_W-1:0];
        mcvp_pkg::REG_PENALTY: cfg_q.step_penalty <= pwdata[mcvp_pkg::PEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (index)
      mcvp_pkg::REG_COLS:    prdata = mcvp_pkg::APB_DATA_W'(cfg_q.cols_in_use);
      mcvp_pkg::REG_ROWS:    prdata = mcvp_pkg::APB_DATA_W'(cfg_q.rows_in_use);
      mcvp_pkg::REG_PENALTY: prdata = mcvp_pkg::APB_DATA_W'(cfg_q.step_penalty);
      default:               prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

### hdl/mcvp_ctrl.sv
// Sequencer and datapath: accumulates path sums through the row memory,
// stores back pointers in the move memory and traces the path on read items.
// Depends on mcvp_pkg, mcvp_if and mcvp_ram.
module mcvp_ctrl #(
  parameter int unsigned MAX_COLS = 256,
  parameter int unsigned MAX_ROWS = 1024,
  parameter int unsigned SUM_BITS = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  mcvp_pkg::cfg_t cfg_i,
  mcvp_in_if.sink        in_i,
  mcvp_out_if.source     out_o
);

  localparam int unsigned CW  = $clog2(MAX_COLS);
  localparam int unsigned CNW = $clog2(MAX_COLS + 1);
  localparam int unsigned RW  = $clog2(MAX_ROWS);
  localparam int unsigned RNW = $clog2(MAX_ROWS + 1);
  localparam int unsigned CEW = (CNW > mcvp_pkg::COLS_W) ? CNW : mcvp_pkg::COLS_W;
  localparam int unsigned REW = (RNW > mcvp_pkg::ROWS_W) ? RNW : mcvp_pkg::ROWS_W;
  localparam int unsigned BM_DEPTH = MAX_ROWS << CW;
  localparam logic [SUM_BITS-1:0] SUM_MAX = {SUM_BITS{1'b1}};

  typedef enum logic [2:0] {
    S_IDLE, S_LD_UP, S_LD_RIGHT, S_LD_PICK, S_LD_WRITE, S_RD_MOVE, S_EMIT
  } state_e;

  function automatic logic [SUM_BITS-1:0] sat_add(input logic [SUM_BITS-1:0] a,
                                                  input logic [SUM_BITS-1:0] b);
    logic [SUM_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SUM_BITS] ? SUM_MAX : s[SUM_BITS-1:0];
  endfunction

  state_e                 state_q;
  logic [CW-1:0]          load_col_q, trace_col_q, best_col_q, best_col_d;
  logic [RW-1:0]          load_row_q, trace_row_q;
  logic [SUM_BITS-1:0]    held_q, best_sum_q, up_q, pick_q;
  logic [1:0]             mv_q;
  logic [mcvp_pkg::COST_W-1:0] cost_q;
  logic                   map_ready_q, out_valid_q;
  mcvp_pkg::res_t         res_q, res_d, out_q;

  logic [CEW-1:0]         cols_ext;
  logic [REW-1:0]         rows_ext;
  logic [CNW-1:0]         cols_eff, tc_ext, tc_new;
  logic [RNW-1:0]         rows_eff;
  logic                   in_acc, restart, col_end, row_end, best_upd, slot_free;
  logic [SUM_BITS-1:0]    pen_ext, cost_ext, left_sum, right_sum, pick_d, sum_d;
  logic [1:0]             mv_d;

  logic                   rs_we;
  logic [CW-1:0]          rs_raddr;
  logic [SUM_BITS-1:0]    rs_rdata;
  logic                   bm_we;
  logic [1:0]             bm_rdata;

  // Out-of-range sizes behave as the nearest legal size.
  assign cols_ext = CEW'(cfg_i.cols_in_use);
  assign rows_ext = REW'(cfg_i.rows_in_use);

  always_comb begin
    if (cols_ext == '0)                 cols_eff = CNW'(1);
    else if (cols_ext > CEW'(MAX_COLS)) cols_eff = CNW'(MAX_COLS);
    else                                cols_eff = CNW'(cols_ext);
    if (rows_ext == '0)                 rows_eff = RNW'(1);
    else if (rows_ext > REW'(MAX_ROWS)) rows_eff = RNW'(MAX_ROWS);
    else                                rows_eff = RNW'(rows_ext);
  end

  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid && (state_q == S_IDLE);
  assign restart    = (CNW'(load_col_q) >= cols_eff) || (RNW'(load_row_q) >= rows_eff);
  assign col_end    = (CNW'(load_col_q) + CNW'(1)) >= cols_eff;
  assign row_end    = (RNW'(load_row_q) + RNW'(1)) >= rows_eff;
  assign slot_free  = !out_valid_q || out_o.ready;

  assign pen_ext  = SUM_BITS'(cfg_i.step_penalty);
  assign cost_ext = SUM_BITS'(cost_q);

  // The upper row is read twice: this column, then the one to its right.
  assign rs_raddr = (state_q == S_LD_RIGHT) ? load_col_q + CW'(1) : load_col_q;
  assign rs_we    = (state_q == S_LD_WRITE);
  assign bm_we    = (state_q == S_LD_WRITE) && (load_row_q != '0);

  always_comb begin
    left_sum  = sat_add((load_col_q == '0) ? up_q : held_q, pen_ext);
    right_sum = sat_add(col_end ? up_q : rs_rdata, pen_ext);
    if (up_q <= left_sum && up_q <= right_sum) begin
      pick_d = up_q;
      mv_d   = mcvp_pkg::MV_UP;
    end else if (left_sum < right_sum) begin
      pick_d = left_sum;
      mv_d   = mcvp_pkg::MV_LEFT;
    end else begin
      pick_d = right_sum;
      mv_d   = mcvp_pkg::MV_RIGHT;
    end
  end

  assign sum_d      = (load_row_q == '0) ? cost_ext : sat_add(pick_q, cost_ext);
  assign best_upd   = row_end && ((load_col_q == '0) || (sum_d < best_sum_q));
  assign best_col_d = best_upd ? load_col_q : best_col_q;

  // One step of the trace back, clamped to the current map width.
  always_comb begin
    tc_ext = CNW'(trace_col_q);
    unique case (bm_rdata)
      mcvp_pkg::MV_LEFT:  tc_new = (tc_ext == '0) ? tc_ext : tc_ext - CNW'(1);
      mcvp_pkg::MV_RIGHT: tc_new = tc_ext + CNW'(1);
      default:            tc_new = tc_ext;
    endcase
    if (tc_new >= cols_eff) tc_new = cols_eff - CNW'(1);
  end

  always_comb begin
    res_d = '0;
    if (!map_ready_q) begin
      res_d.status = 1'b1;
    end else begin
      res_d.path_row = mcvp_pkg::PROW_W'(trace_row_q);
      res_d.path_col = mcvp_pkg::PCOL_W'(trace_col_q);
      res_d.last     = (trace_row_q == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      load_col_q  <= '0;
      load_row_q  <= '0;
      held_q      <= '0;
      best_sum_q  <= SUM_MAX;
      best_col_q  <= '0;
      trace_row_q <= '0;
      trace_col_q <= '0;
      map_ready_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == S_EMIT && slot_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            if (in_i.mode == mcvp_pkg::MODE_LOAD) begin
              map_ready_q <= 1'b0;
              if (restart) begin
                load_col_q <= '0;
                load_row_q <= '0;
              end
              state_q <= S_LD_UP;
            end else if (map_ready_q && trace_row_q != '0) begin
              state_q <= S_RD_MOVE;
            end else begin
              // Row 0 ends the path; later reads report a drained path.
              if (map_ready_q) map_ready_q <= 1'b0;
              state_q <= S_EMIT;
            end
          end
        end
        S_LD_UP:    state_q <= S_LD_RIGHT;
        S_LD_RIGHT: state_q <= S_LD_PICK;
        S_LD_PICK:  state_q <= S_LD_WRITE;
        S_LD_WRITE: begin
          if (load_row_q != '0) held_q <= up_q;
          if (best_upd) begin
            best_sum_q <= sum_d;
            best_col_q <= load_col_q;
          end
          if (col_end) begin
            load_col_q <= '0;
            if (row_end) begin
              load_row_q  <= '0;
              map_ready_q <= 1'b1;
              trace_row_q <= load_row_q;
              trace_col_q <= best_col_d;
            end else begin
              load_row_q <= load_row_q + RW'(1);
            end
          end else begin
            load_col_q <= load_col_q + CW'(1);
          end
          state_q <= S_IDLE;
        end
        S_RD_MOVE: begin
          trace_col_q <= CW'(tc_new);
          trace_row_q <= trace_row_q - RW'(1);
          state_q     <= S_EMIT;
        end
        S_EMIT: begin
          if (slot_free) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cost_q <= in_i.cost;
      res_q  <= res_d;
    end
    if (state_q == S_LD_RIGHT) up_q <= rs_rdata;
    if (state_q == S_LD_PICK) begin
      pick_q <= pick_d;
      mv_q   <= mv_d;
    end
    if (state_q == S_EMIT && slot_free) out_q <= res_q;
  end

  mcvp_ram #(
    .WIDTH (SUM_BITS),
    .DEPTH (MAX_COLS)
  ) u_row_sums (
    .clk_i   (clk_i),
    .we_i    (rs_we),
    .waddr_i (load_col_q),
    .wdata_i (sum_d),
    .raddr_i (rs_raddr),
    .rdata_o (rs_rdata)
  );

  mcvp_ram #(
    .WIDTH (2),
    .DEPTH (BM_DEPTH)
  ) u_back_moves (
    .clk_i   (clk_i),
    .we_i    (bm_we),
    .waddr_i ({load_row_q, load_col_q}),
    .wdata_i (mv_q),
    .raddr_i ({trace_row_q, trace_col_q}),
    .rdata_o (bm_rdata)
  );

  assign out_o.valid    = out_valid_q;
  assign out_o.status   = out_q.status;
  assign out_o.path_row = out_q.path_row;
  assign out_o.path_col = out_q.path_col;
  assign out_o.last     = out_q.last;

endmodule

### hdl/mcvp_chk.sv
// Port-level checks for the least-cost path block, bound to the top level.
// Depends on mcvp_pkg for field widths.
module mcvp_chk (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          out_status,
  input logic [mcvp_pkg::PROW_W-1:0]   out_row,
  input logic [mcvp_pkg::PCOL_W-1:0]   out_col,
  input logic                          out_last
);

  // A waiting result must not change until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_row)
      && $stable(out_col) && $stable(out_last))
    else $error("result changed while stalled");

  // Every accepted item makes the block busy, so in_ready drops after each acceptance.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted on consecutive cycles");

  a_status_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_status |-> out_row == '0 && out_col == '0 && !out_last)
    else $error("error result carries a path point");

  a_last_row0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_status && out_last |-> out_row == '0)
    else $error("last flagged away from row 0");

  // A fresh result is only presented after the block was busy with an item.
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared without a read in progress");

endmodule

bind min_cost_vertical_path_dp_top mcvp_chk u_chk (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid   (in_i.valid),
  .in_ready   (in_i.ready),
  .out_valid  (out_o.valid),
  .out_ready  (out_o.ready),
  .out_status (out_o.status),
  .out_row    (out_o.path_row),
  .out_col    (out_o.path_col),
  .out_last   (out_o.last)
);
